>>> rtl/i2cm_pkg.sv
// Shared types, codes and helpers for the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

  localparam int DLY_W  = 10;
  localparam int POLL_W = 8;
  localparam int CFG_W  = 10;
  localparam int IDX_W  = 2;

  localparam logic [31:0] DLY_MAX = (32'd1 << DLY_W) - 32'd1;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_WAIT  = 3'd4;
  localparam logic [2:0] REQ_CHECK = 3'd5;

  localparam logic [IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ACK_SETUP   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_POLL_LIMIT  = 2'd2;

  typedef enum logic [14:0] {
    PH_IDLE = 15'b000000000000001,
    PH_ST1  = 15'b000000000000010,
    PH_ST2  = 15'b000000000000100,
    PH_SP1  = 15'b000000000001000,
    PH_SP2  = 15'b000000000010000,
    PH_WR1  = 15'b000000000100000,
    PH_WR2  = 15'b000000001000000,
    PH_WR3  = 15'b000000010000000,
    PH_RD1  = 15'b000000100000000,
    PH_RD2  = 15'b000001000000000,
    PH_RK1  = 15'b000010000000000,
    PH_RK2  = 15'b000100000000000,
    PH_WA1  = 15'b001000000000000,
    PH_WA2  = 15'b010000000000000,
    PH_WA3  = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0]  half_period;
    logic [CFG_W-1:0]  ack_setup;
    logic [POLL_W-1:0] poll_limit;
  } cfg_t;

  // A programmed delay of zero behaves as one tick, and a delay beyond the
  // counter range saturates to the counter maximum.
  function automatic logic [DLY_W-1:0] load_delay(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    if (w > DLY_MAX) w = DLY_MAX;
    return w[DLY_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/i2c_master_bit_engine_unit.sv
// Top level: configuration registers, input register, sequencer and result register.
// A tick waits in the input register; its result is taken into the result register.
// One tick per cycle unless stalled, set by the single-pass sequencer step.
// While a finished result waits downstream, the input register takes one more tick
// and then stalls the input.
// Reset (rst_n low, synchronous) idles the bus with SCL and SDA driven high.
// Reset also restores the delay and poll registers to 10, 6 and 250.
`default_nettype none
module i2c_master_bit_engine_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [i2cm_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [i2cm_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_cmd_valid,
  input  wire logic [2:0]                in_req_type,
  input  wire logic [7:0]                in_tx_byte,
  input  wire logic                      in_send_ack,
  input  wire logic                      in_sda_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_scl_level,
  output logic                           out_sda_level,
  output logic                           out_sda_drive,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [7:0]                     out_rx_byte,
  output logic                           out_ack_error
);
  import i2cm_pkg::*;

  cfg_t cfg_r;
  in_t  in_data_r;
  logic in_v_r;
  logic out_v_r;
  res_t res;
  res_t out_data_r;
  logic adv;
  logic in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= CFG_W'(10);
      cfg_r.ack_setup   <= CFG_W'(6);
      cfg_r.poll_limit  <= POLL_W'(250);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HALF_PERIOD: cfg_r.half_period <= cfg_wdata;
        CFG_ACK_SETUP:   cfg_r.ack_setup   <= cfg_wdata;
        CFG_POLL_LIMIT:  cfg_r.poll_limit  <= cfg_wdata[POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r.cmd_valid <= in_cmd_valid;
      in_data_r.req_type  <= in_req_type;
      in_data_r.tx_byte   <= in_tx_byte;
      in_data_r.send_ack  <= in_send_ack;
      in_data_r.sda_in    <= in_sda_in;
    end
  end

  i2cm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (in_data_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_scl_level = out_data_r.scl_level;
  assign out_sda_level = out_data_r.sda_level;
  assign out_sda_drive = out_data_r.sda_drive;
  assign out_busy_res  = out_data_r.busy_res;
  assign out_done_res  = out_data_r.done_res;
  assign out_rx_byte   = out_data_r.rx_byte;
  assign out_ack_error = out_data_r.ack_error;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_data_r.done_res && out_data_r.busy_res))
    else $error("result marks a transaction both done and busy");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("sequencer step produced no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && !adv))
    else $error("input stalled while the pipeline could advance");

  a_pending_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> (out_v_r && $stable(out_data_r)))
    else $error("stalled result was lost or changed");

endmodule
`default_nettype wire

>>> rtl/i2cm_core.sv
// Bus sequencer state and the per-tick next-state and result logic.
`default_nettype none
module i2cm_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire i2cm_pkg::in_t  item,
  input  wire i2cm_pkg::cfg_t cfg,
  output i2cm_pkg::res_t     res
);
  import i2cm_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [DLY_W-1:0]  dly_r, dly_nxt;
  logic [POLL_W-1:0] poll_r, poll_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              drv_r, drv_nxt;
  logic              aerr_r, aerr_nxt;
  logic              ackc_r, ackc_nxt;
  logic              cmpd_r, cmpd_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              done;
  logic              go_start, go_stop, go_done, go_wbit, go_wait, go_rlow;
  logic              first_bit;
  logic [7:0]        wsrc;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    dly_nxt   = dly_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    aerr_nxt  = aerr_r;
    ackc_nxt  = ackc_r;
    cmpd_nxt  = cmpd_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    go_start  = 1'b0;
    go_stop   = 1'b0;
    go_done   = 1'b0;
    go_wbit   = 1'b0;
    go_wait   = 1'b0;
    go_rlow   = 1'b0;
    first_bit = 1'b0;
    wsrc      = shift_r;

    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid) begin
        unique case (item.req_type)
          REQ_START: begin
            cmpd_nxt = 1'b0;
            go_start = 1'b1;
          end
          REQ_STOP: begin
            cmpd_nxt = 1'b0;
            go_stop  = 1'b1;
          end
          REQ_WRITE: begin
            cmpd_nxt  = 1'b0;
            wsrc      = item.tx_byte;
            first_bit = 1'b1;
            go_wbit   = 1'b1;
          end
          REQ_READ: begin
            cmpd_nxt  = 1'b0;
            shift_nxt = '0;
            bit_nxt   = '0;
            ackc_nxt  = item.send_ack;
            go_rlow   = 1'b1;
          end
          REQ_WAIT: begin
            cmpd_nxt = 1'b0;
            aerr_nxt = 1'b0;
            go_wait  = 1'b1;
          end
          REQ_CHECK: begin
            cmpd_nxt  = 1'b1;
            aerr_nxt  = 1'b0;
            shift_nxt = item.tx_byte;
            go_start  = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (phase_r != PH_WA3 && dly_r > DLY_W'(1)) begin
      dly_nxt = dly_r - DLY_W'(1);
    end else begin
      unique case (phase_r) inside
        PH_ST1: begin
          sda_nxt   = 1'b0;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_ST2;
        end
        PH_ST2: begin
          scl_nxt = 1'b0;
          if (cmpd_r) begin
            first_bit = 1'b1;
            go_wbit   = 1'b1;
          end else begin
            go_done = 1'b1;
          end
        end
        PH_SP1: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_SP2;
        end
        PH_SP2: go_done = 1'b1;
        PH_WR1: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_WR2;
        end
        PH_WR2: begin
          scl_nxt   = 1'b0;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_WR3;
        end
        PH_WR3: begin
          if (bit_r < 4'd8) go_wbit = 1'b1;
          else if (cmpd_r)  go_wait = 1'b1;
          else              go_done = 1'b1;
        end
        PH_RD1: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], item.sda_in};
          bit_nxt   = bit_r + 4'd1;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_RD2;
        end
        PH_RD2: begin
          if (bit_r < 4'd8) begin
            go_rlow = 1'b1;
          end else begin
            scl_nxt   = 1'b0;
            drv_nxt   = 1'b1;
            sda_nxt   = ~ackc_r;
            dly_nxt   = load_delay(cfg.half_period);
            phase_nxt = PH_RK1;
          end
        end
        PH_RK1: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.half_period);
          phase_nxt = PH_RK2;
        end
        PH_RK2: begin
          scl_nxt = 1'b0;
          rx_nxt  = shift_r;
          go_done = 1'b1;
        end
        PH_WA1: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.ack_setup);
          phase_nxt = PH_WA2;
        end
        PH_WA2, PH_WA3: begin
          phase_nxt = PH_WA3;
          if (!item.sda_in) begin
            scl_nxt = 1'b0;
            if (cmpd_r) go_stop = 1'b1;
            else        go_done = 1'b1;
          end else if (poll_r >= cfg.poll_limit) begin
            aerr_nxt = 1'b1;
            go_stop  = 1'b1;
          end else begin
            poll_nxt = poll_r + POLL_W'(1);
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (go_start) begin
      drv_nxt   = 1'b1;
      sda_nxt   = 1'b1;
      scl_nxt   = 1'b1;
      dly_nxt   = load_delay(cfg.half_period);
      phase_nxt = PH_ST1;
    end
    if (go_stop) begin
      drv_nxt   = 1'b1;
      scl_nxt   = 1'b0;
      sda_nxt   = 1'b0;
      dly_nxt   = load_delay(cfg.half_period);
      phase_nxt = PH_SP1;
    end
    if (go_wbit) begin
      scl_nxt   = 1'b0;
      drv_nxt   = 1'b1;
      sda_nxt   = wsrc[7];
      shift_nxt = {wsrc[6:0], 1'b0};
      bit_nxt   = first_bit ? 4'd1 : bit_r + 4'd1;
      dly_nxt   = load_delay(cfg.half_period);
      phase_nxt = PH_WR1;
    end
    if (go_rlow) begin
      scl_nxt   = 1'b0;
      drv_nxt   = 1'b0;
      sda_nxt   = 1'b1;
      dly_nxt   = load_delay(cfg.half_period);
      phase_nxt = PH_RD1;
    end
    if (go_wait) begin
      poll_nxt  = '0;
      drv_nxt   = 1'b0;
      sda_nxt   = 1'b1;
      dly_nxt   = load_delay(cfg.ack_setup);
      phase_nxt = PH_WA1;
    end
    if (go_done) begin
      phase_nxt = PH_IDLE;
      cmpd_nxt  = 1'b0;
      done      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      dly_r   <= '0;
      poll_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      aerr_r  <= 1'b0;
      ackc_r  <= 1'b0;
      cmpd_r  <= 1'b0;
      rx_r    <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      dly_r   <= dly_nxt;
      poll_r  <= poll_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      aerr_r  <= aerr_nxt;
      ackc_r  <= ackc_nxt;
      cmpd_r  <= cmpd_nxt;
      rx_r    <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.sda_drive = drv_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_nxt;
    res.ack_error = aerr_nxt;
  end

endmodule
`default_nettype wire
